// File: rtl/core/dau_pkg.sv
// Package for the duration arithmetic unit: command codes and constants.
// No dependencies.
package dau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_LT  = 3'd3,
    CMD_EQ  = 3'd4
  } cmd_t;

  localparam logic signed [31:0] NS_PER_S = 32'sd1000000000;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

// File: rtl/core/duration_arithmetic_unit.sv
// Duration arithmetic unit: add, subtract, scale and compare sec/ns durations.
// Depends on dau_pkg.
//
// Takes one beat per cycle; busy is always low. Each beat gives exactly one
// result beat, marked by out_valid, after it has passed the pipeline: operand
// check, 32x32 partial products, product combine with reciprocal quotient
// estimate, remainder product, quotient correction, then seconds carry and
// normalize into the output register.
module duration_arithmetic_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_command,
  input  logic signed [63:0]  in_a_seconds,
  input  logic signed [31:0]  in_a_nanoseconds,
  input  logic signed [63:0]  in_b_seconds,
  input  logic signed [31:0]  in_b_nanoseconds,
  input  logic signed [31:0]  in_multiplier,
  output logic                out_valid,
  output logic signed [63:0]  out_result_seconds,
  output logic signed [30:0]  out_result_nanoseconds,
  output logic                out_invalid,
  output logic                out_compare_true
);
  import dau_pkg::*;

  assign busy = 1'b0;

  // stage 1: check operands, take magnitudes, form addend for subtract
  logic [4:0]  v_r;
  logic [2:0]  cmd1_r;
  logic        ok1_r, iscmp1_r, cmp1_r, neg1_r;
  logic [63:0] as1_r, bs1_r;
  logic [31:0] an1_r, bn1_r;
  logic [63:0] maga1_r;
  logic [31:0] magm1_r;
  logic signed [31:0] m1_r;

  logic        va, vb, ok1_nxt, cmp1_nxt, iscmp1_nxt;
  logic [63:0] bs1_nxt;
  logic [31:0] bn1_nxt;

  always_comb begin
    va = !in_a_nanoseconds[31] && (in_a_nanoseconds < NS_PER_S);
    vb = !in_b_nanoseconds[31] && (in_b_nanoseconds < NS_PER_S);
    ok1_nxt = 1'b0;
    cmp1_nxt = 1'b0;
    iscmp1_nxt = 1'b0;
    bs1_nxt = in_b_seconds;
    bn1_nxt = in_b_nanoseconds;
    case (in_command)
      CMD_ADD: ok1_nxt = va && vb;
      CMD_SUB: begin
        if (in_b_nanoseconds == 32'sd0) begin
          ok1_nxt = va && vb && (in_b_seconds != S64_MIN);
          bs1_nxt = 64'd0 - in_b_seconds;
        end else begin
          ok1_nxt = va && vb;
          bs1_nxt = ~in_b_seconds;
          bn1_nxt = NS_PER_S - in_b_nanoseconds;
        end
      end
      CMD_MUL: ok1_nxt = va;
      CMD_LT: begin
        iscmp1_nxt = 1'b1;
        ok1_nxt = va && vb;
        cmp1_nxt = va && vb && ((in_a_seconds < in_b_seconds) ||
          (in_a_seconds == in_b_seconds && in_a_nanoseconds < in_b_nanoseconds));
      end
      CMD_EQ: begin
        iscmp1_nxt = 1'b1;
        ok1_nxt = va && vb;
        cmp1_nxt = va && vb && in_a_seconds == in_b_seconds &&
          in_a_nanoseconds == in_b_nanoseconds;
      end
      default: ok1_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r   <= in_command;
    ok1_r    <= ok1_nxt;
    iscmp1_r <= iscmp1_nxt;
    cmp1_r   <= cmp1_nxt;
    as1_r    <= in_a_seconds;
    an1_r    <= in_a_nanoseconds;
    bs1_r    <= bs1_nxt;
    bn1_r    <= bn1_nxt;
    m1_r     <= in_multiplier;
    maga1_r  <= in_a_seconds[63] ? 64'd0 - in_a_seconds : in_a_seconds;
    magm1_r  <= in_multiplier[31] ? 32'd0 - in_multiplier : in_multiplier;
    neg1_r   <= in_a_seconds[63] ^ in_multiplier[31];
  end

  // stage 2: partial products; seconds sum for add/sub
  logic [2:0]  cmd2_r;
  logic        ok2_r, iscmp2_r, cmp2_r, neg2_r, sovf2_r, nneg2_r;
  logic [63:0] plo2_r, phi2_r, s2_r;
  logic [63:0] pabs2_r;
  logic [31:0] ns2_r;
  logic [63:0] ssum;

  assign ssum = as1_r + bs1_r;

  always_ff @(posedge clk) begin
    cmd2_r   <= cmd1_r;
    ok2_r    <= ok1_r;
    iscmp2_r <= iscmp1_r;
    cmp2_r   <= cmp1_r;
    neg2_r   <= neg1_r;
    plo2_r   <= {32'd0, maga1_r[31:0]} * {32'd0, magm1_r};
    phi2_r   <= {32'd0, maga1_r[63:32]} * {32'd0, magm1_r};
    pabs2_r  <= {32'd0, an1_r} * {32'd0, magm1_r};
    nneg2_r  <= m1_r[31];
    s2_r     <= ssum;
    sovf2_r  <= ((as1_r ^ ssum) & (bs1_r ^ ssum)) >> 63 != 64'd0;
    ns2_r    <= an1_r + bn1_r;
  end

  // stage 3: combine product magnitude; estimate ns product / 1e9
  // |p| < 2^61: q = (p[60:29] * floor(2^61/1e9)) >> 32, low by at most two
  localparam logic [31:0] RECIP = 32'd2305843009;
  logic [2:0]  cmd3_r;
  logic        ok3_r, iscmp3_r, cmp3_r, neg3_r, movf3_r, nneg3_r;
  logic [63:0] mag3_r, s3_r;
  logic        sovf3_r;
  logic [31:0] ns3_r;
  logic [63:0] qp3_r;
  logic [33:0] p3_r;
  logic [64:0] msum;

  assign msum = {1'b0, phi2_r[31:0], 32'd0} + {1'b0, plo2_r};

  always_ff @(posedge clk) begin
    cmd3_r   <= cmd2_r;
    ok3_r    <= ok2_r;
    iscmp3_r <= iscmp2_r;
    cmp3_r   <= cmp2_r;
    neg3_r   <= neg2_r;
    mag3_r   <= msum[63:0];
    movf3_r  <= (phi2_r[63:32] != 32'd0) || msum[64] ||
      (msum[63:0] > (neg2_r ? S64_MIN : S64_MAX));
    nneg3_r  <= nneg2_r;
    qp3_r    <= {32'd0, pabs2_r[60:29]} * {32'd0, RECIP};
    p3_r     <= pabs2_r[33:0];
    s3_r     <= s2_r;
    sovf3_r  <= sovf2_r;
    ns3_r    <= ns2_r;
  end

  // stage 4: signed product, quotient estimate times 1e9
  logic [2:0]  cmd4_r;
  logic        ok4_r, iscmp4_r, cmp4_r, sovf4_r, nneg4_r;
  logic [63:0] s4_r, prod4_r;
  logic [31:0] qe4_r;
  logic [33:0] qm4_r, p4_r;
  logic [31:0] ns4_r;
  logic [63:0] qm;

  assign qm = {32'd0, qp3_r[63:32]} * {32'd0, NS_PER_S};

  always_ff @(posedge clk) begin
    cmd4_r   <= cmd3_r;
    iscmp4_r <= iscmp3_r;
    cmp4_r   <= cmp3_r;
    ok4_r    <= ok3_r && !(cmd3_r == CMD_MUL && movf3_r);
    prod4_r  <= neg3_r ? 64'd0 - mag3_r : mag3_r;
    qe4_r    <= qp3_r[63:32];
    qm4_r    <= qm[33:0];
    p4_r     <= p3_r;
    nneg4_r  <= nneg3_r;
    s4_r     <= s3_r;
    sovf4_r  <= sovf3_r;
    ns4_r    <= ns3_r;
  end

  // stage 5: correct quotient, signed quotient and remainder
  localparam logic [33:0] NS1_34 = 34'd1000000000;
  localparam logic [33:0] NS2_34 = 34'd2000000000;
  logic [2:0]  cmd5_r;
  logic        ok5_r, iscmp5_r, cmp5_r, sovf5_r;
  logic [63:0] s5_r, prod5_r, q5_r;
  logic signed [31:0] rem5_r;
  logic [31:0] ns5_r;
  logic [33:0] r0, rc;
  logic [31:0] qc;

  always_comb begin
    r0 = p4_r - qm4_r;
    if (r0 >= NS2_34) begin
      qc = qe4_r + 32'd2;
      rc = r0 - NS2_34;
    end else if (r0 >= NS1_34) begin
      qc = qe4_r + 32'd1;
      rc = r0 - NS1_34;
    end else begin
      qc = qe4_r;
      rc = r0;
    end
  end

  always_ff @(posedge clk) begin
    cmd5_r   <= cmd4_r;
    iscmp5_r <= iscmp4_r;
    cmp5_r   <= cmp4_r;
    ok5_r    <= ok4_r;
    prod5_r  <= prod4_r;
    q5_r     <= nneg4_r ? 64'd0 - {32'd0, qc} : {32'd0, qc};
    rem5_r   <= nneg4_r ? 32'd0 - rc[31:0] : rc[31:0];
    s5_r     <= s4_r;
    sovf5_r  <= sovf4_r;
    ns5_r    <= ns4_r;
  end

  // stage 6: final carry/borrow and result formatting
  logic        ok6;
  logic [63:0] rs6, msec;
  logic [31:0] rn6;

  always_comb begin
    msec = prod5_r + q5_r;
    ok6 = ok5_r;
    rs6 = s5_r;
    rn6 = ns5_r;
    if (cmd5_r == CMD_MUL) begin
      rn6 = rem5_r;
      rs6 = msec;
      if (((prod5_r ^ msec) & (q5_r ^ msec)) >> 63 != 64'd0) begin
        ok6 = 1'b0;
      end else if (rem5_r < 0) begin
        if (msec == S64_MIN) begin
          ok6 = 1'b0;
        end else begin
          rs6 = msec - 64'd1;
          rn6 = rem5_r + NS_PER_S;
        end
      end
    end else begin
      if (sovf5_r) begin
        ok6 = 1'b0;
      end else if (ns5_r >= NS_PER_S) begin
        if (s5_r == S64_MAX) begin
          ok6 = 1'b0;
        end else begin
          rs6 = s5_r + 64'd1;
          rn6 = ns5_r - NS_PER_S;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (iscmp5_r) begin
      out_result_seconds     <= '0;
      out_result_nanoseconds <= '0;
      out_invalid            <= !ok5_r;
      out_compare_true       <= cmp5_r;
    end else if (ok6) begin
      out_result_seconds     <= rs6;
      out_result_nanoseconds <= rn6[30:0];
      out_invalid            <= 1'b0;
      out_compare_true       <= 1'b0;
    end else begin
      out_result_seconds     <= '0;
      out_result_nanoseconds <= '1;
      out_invalid            <= 1'b1;
      out_compare_true       <= 1'b0;
    end
  end

endmodule

// File: tb/sv/tb_duration_arithmetic_unit.sv
// Testbench for duration_arithmetic_unit: a directed table, then random beats,
// checked against typed expectations or a local predictor. Depends on dau_pkg.
module tb_duration_arithmetic_unit;
  import dau_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1030;
  localparam logic signed [63:0] NS_ONE_S = 64'sd1000000000;

  typedef struct {
    logic [63:0] sec;
    logic [30:0] ns;
    logic        inv;
    logic        cmp;
  } duration_result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] a_s;
    logic [31:0] a_n;
    logic [63:0] b_s;
    logic [31:0] b_n;
    logic [31:0] mult;
    bit          typed;
    logic [63:0] e_sec;
    logic [30:0] e_ns;
    logic        e_inv;
    logic        e_cmp;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_command;
  logic signed [63:0] in_a_seconds;
  logic signed [31:0] in_a_nanoseconds;
  logic signed [63:0] in_b_seconds;
  logic signed [31:0] in_b_nanoseconds;
  logic signed [31:0] in_multiplier;
  logic               out_valid;
  logic signed [63:0] out_result_seconds;
  logic signed [30:0] out_result_nanoseconds;
  logic               out_invalid;
  logic               out_compare_true;

  duration_result_t expected_results[$];
  duration_result_t typed_result;
  bit               use_typed;
  int               fail_count = 0;
  int               idle_cycles = 0;
  stim_row_t        table_rows[$];

  duration_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_a_seconds(in_a_seconds),
    .in_a_nanoseconds(in_a_nanoseconds), .in_b_seconds(in_b_seconds),
    .in_b_nanoseconds(in_b_nanoseconds), .in_multiplier(in_multiplier),
    .out_valid(out_valid), .out_result_seconds(out_result_seconds),
    .out_result_nanoseconds(out_result_nanoseconds), .out_invalid(out_invalid),
    .out_compare_true(out_compare_true)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit sum_durations(input logic [63:0] as, input logic signed [63:0] an,
                                       input logic [63:0] bs, input logic signed [63:0] bn,
                                       output logic [63:0] rs,
                                       output logic signed [63:0] rn);
    logic [63:0] s;
    logic signed [63:0] n;
    s = as + bs;
    n = an + bn;
    rs = 64'd0;
    rn = 64'sd0;
    if (((as ^ s) & (bs ^ s)) >> 63) return 1'b0;
    if (n >= NS_ONE_S) begin
      if (s == S64_MAX) return 1'b0;
      n = n - NS_ONE_S;
      s = s + 64'd1;
    end
    rs = s;
    rn = n;
    return 1'b1;
  endfunction

  function automatic duration_result_t compute_duration_result(
      input logic [2:0] cmd, input logic [63:0] as, input logic [31:0] an32,
      input logic [63:0] bs, input logic [31:0] bn32, input logic [31:0] m32);
    duration_result_t r;
    logic signed [63:0] an, bn, m, prod, rest, rem, rn;
    logic signed [127:0] full;
    logic [63:0] s, rs;
    bit va, vb, ok, cmp, is_cmp;
    an = $signed(an32);
    bn = $signed(bn32);
    m = $signed(m32);
    va = an >= 0 && an < NS_ONE_S;
    vb = bn >= 0 && bn < NS_ONE_S;
    ok = 0;
    cmp = 0;
    is_cmp = 0;
    rs = 64'd0;
    rn = 64'sd0;
    case (cmd)
      CMD_ADD: ok = va && vb && sum_durations(as, an, bs, bn, rs, rn);
      CMD_SUB: begin
        if (va && vb) begin
          if (bn == 0) ok = bs != S64_MIN && sum_durations(as, an, -bs, 64'sd0, rs, rn);
          else ok = sum_durations(as, an, ~bs, NS_ONE_S - bn, rs, rn);
        end
      end
      CMD_MUL: begin
        if (va) begin
          full = $signed(as) * m;
          prod = an * m;
          rest = prod / NS_ONE_S;
          rem = prod % NS_ONE_S;
          ok = full >= -(128'sd1 <<< 63) && full <= $signed({64'd0, S64_MAX});
          s = full[63:0];
          if (ok) begin
            rs = s + rest;
            if (((s ^ rs) & (rest ^ rs)) >> 63) ok = 0;
            s = rs;
          end
          if (ok && rem < 0) begin
            if (s == S64_MIN) ok = 0;
            else begin
              rem = rem + NS_ONE_S;
              s = s - 64'd1;
            end
          end
          rs = s;
          rn = rem;
        end
      end
      CMD_LT, CMD_EQ: begin
        is_cmp = 1;
        ok = va && vb;
        if (ok) begin
          if (cmd == CMD_LT) cmp = $signed(as) < $signed(bs) || (as == bs && an < bn);
          else cmp = as == bs && an == bn;
        end
      end
      default: ok = 0;
    endcase
    if (is_cmp) begin
      r.sec = 64'd0; r.ns = 31'd0; r.inv = !ok; r.cmp = cmp;
    end else if (ok) begin
      r.sec = rs; r.ns = rn[30:0]; r.inv = 1'b0; r.cmp = 1'b0;
    end else begin
      r.sec = 64'd0; r.ns = 31'h7FFF_FFFF; r.inv = 1'b1; r.cmp = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    duration_result_t e;
    bit moved;
    moved = 0;
    if (rst_n && out_valid) begin
      moved = 1;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_result_seconds !== e.sec) begin
          $error("result_seconds expected %0h got %0h", e.sec, out_result_seconds);
          fail_count++;
        end
        if (out_result_nanoseconds !== e.ns) begin
          $error("result_nanoseconds expected %0h got %0h", e.ns, out_result_nanoseconds);
          fail_count++;
        end
        if (out_invalid !== e.inv) begin
          $error("invalid expected %0b got %0b", e.inv, out_invalid);
          fail_count++;
        end
        if (out_compare_true !== e.cmp) begin
          $error("compare_true expected %0b got %0b", e.cmp, out_compare_true);
          fail_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      moved = 1;
      if (use_typed) expected_results.push_back(typed_result);
      else expected_results.push_back(compute_duration_result(in_command, in_a_seconds,
        in_a_nanoseconds, in_b_seconds, in_b_nanoseconds, in_multiplier));
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("duration_arithmetic_unit verification failed");
      $finish;
    end
  end

  function automatic stim_row_t row(input logic [2:0] cmd, input logic [63:0] as,
                                    input logic [31:0] an, input logic [63:0] bs,
                                    input logic [31:0] bn, input logic [31:0] mult);
    stim_row_t r;
    r.cmd = cmd; r.a_s = as; r.a_n = an; r.b_s = bs; r.b_n = bn; r.mult = mult;
    r.typed = 0; r.e_sec = 0; r.e_ns = 0; r.e_inv = 0; r.e_cmp = 0;
    return r;
  endfunction

  function automatic stim_row_t with_exp(input stim_row_t r, input logic [63:0] sec,
                                         input logic [30:0] ns, input logic inv,
                                         input logic cmp);
    r.typed = 1; r.e_sec = sec; r.e_ns = ns; r.e_inv = inv; r.e_cmp = cmp;
    return r;
  endfunction

  function automatic stim_row_t bad(input stim_row_t r);
    return with_exp(r, 64'd0, 31'h7FFF_FFFF, 1'b1, 1'b0);
  endfunction

  task automatic send_beat(input stim_row_t r, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= r.cmd;
    in_a_seconds <= r.a_s;
    in_a_nanoseconds <= r.a_n;
    in_b_seconds <= r.b_s;
    in_b_nanoseconds <= r.b_n;
    in_multiplier <= r.mult;
    use_typed <= r.typed;
    typed_result <= '{r.e_sec, r.e_ns, r.e_inv, r.e_cmp};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_ns();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return 32'd999999999;
      2: return 32'd1000000000;
      3: return $urandom();
      4: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 999999999);
    endcase
  endfunction

  function automatic logic [63:0] pick_sec();
    case ($urandom_range(0, 9))
      0: return S64_MAX - $urandom_range(0, 3);
      1: return S64_MIN + $urandom_range(0, 3);
      2, 3: return {{32{1'b0}}, $urandom()} - 64'h8000_0000;
      4: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [31:0] pick_mult();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    stim_row_t r;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ADD;
    in_a_seconds = 0;
    in_a_nanoseconds = 0;
    in_b_seconds = 0;
    in_b_nanoseconds = 0;
    in_multiplier = 0;
    use_typed = 0;
    typed_result = '{64'd0, 31'd0, 1'b0, 1'b0};

    table_rows.push_back(with_exp(row(CMD_ADD, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    table_rows.push_back(bad(row(CMD_ADD, S64_MAX, 999999999, 0, 1, 0)));
    table_rows.push_back(bad(row(CMD_ADD, 5, 32'hFFFF_FFFF, 1, 0, 0)));
    table_rows.push_back(bad(row(CMD_ADD, 5, 0, 1, 1000000000, 0)));
    table_rows.push_back(bad(row(CMD_ADD, S64_MIN, 500000000, -64'sd1, 600000000, 0)));
    table_rows.push_back(row(CMD_ADD, S64_MAX - 1, 999999999, 0, 999999999, 0));
    table_rows.push_back(bad(row(CMD_SUB, 0, 0, S64_MIN, 0, 0)));
    table_rows.push_back(bad(row(CMD_SUB, S64_MIN, 0, 0, 1, 0)));
    table_rows.push_back(row(CMD_SUB, 3, 250000000, 1, 750000000, 0));
    table_rows.push_back(bad(row(CMD_MUL, S64_MAX, 0, 0, 0, 2)));
    table_rows.push_back(bad(row(CMD_MUL, S64_MIN, 0, 0, 0, 32'hFFFF_FFFF)));
    table_rows.push_back(row(CMD_MUL, 1, 999999999, 0, 0, 32'h8000_0000));
    table_rows.push_back(row(CMD_MUL, 0, 1, 0, 0, 32'hFFFF_FFFF));
    table_rows.push_back(bad(row(CMD_MUL, 64'h4000_0000_0000_0000, 1, 0, 0, 32'hFFFF_FFFE)));
    table_rows.push_back(bad(row(CMD_MUL, 7, 32'h8000_0000, 0, 32'hFFFF_FFFF, 3)));
    table_rows.push_back(row(CMD_MUL, 7, 123, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    table_rows.push_back(with_exp(row(CMD_LT, S64_MIN, 0, S64_MAX, 999999999, 0), 0, 0, 0, 1));
    table_rows.push_back(with_exp(row(CMD_LT, 9, 5, 9, 5, 0), 0, 0, 0, 0));
    table_rows.push_back(row(CMD_LT, 9, 4, 9, 5, 0));
    table_rows.push_back(with_exp(row(CMD_EQ, S64_MAX, 999999999, S64_MAX, 999999999, 0),
                                  0, 0, 0, 1));
    table_rows.push_back(with_exp(row(CMD_EQ, 1, 1, 1, 32'h8000_0000, 0), 0, 0, 1, 0));
    table_rows.push_back(bad(row(3'd5, 1, 1, 1, 1, 1)));
    table_rows.push_back(bad(row(3'd6, 0, 0, 0, 0, 0)));
    table_rows.push_back(bad(row(3'd7, S64_MAX, 999999999, S64_MAX, 999999999, 32'hFFFF_FFFF)));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (table_rows[i]) send_beat(table_rows[i], 1'b1);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      r = row(3'($urandom_range(0, 19) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4)),
              pick_sec(), pick_ns(), pick_sec(), pick_ns(), pick_mult());
      if ($urandom_range(0, 3) == 0) r.b_s = r.a_s;
      if ($urandom_range(0, 5) == 0) r.b_n = r.a_n;
      send_beat(r, i < RANDOM_BEATS - 150);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("duration_arithmetic_unit verification clean");
    else $display("duration_arithmetic_unit verification failed");
    $finish;
  end
endmodule

// File: files.f
rtl/core/dau_pkg.sv
rtl/core/duration_arithmetic_unit.sv
tb/sv/tb_duration_arithmetic_unit.sv
